// ===== src/frame_rate_text_overlay_unit_defines.svh =====
// Assertion macros shared by the frame-rate overlay RTL.
`ifndef FRAME_RATE_TEXT_OVERLAY_UNIT_DEFINES_SVH
`define FRAME_RATE_TEXT_OVERLAY_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define FRTOV_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("frtov: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define FRTOV_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("frtov: next-cycle check failed");

`endif

// ===== src/frtov_pkg.sv =====
// Types, constants and font table of the frame-rate text overlay.
package frtov_pkg;

   localparam int unsigned COLOR_W = 32;
   localparam int unsigned X_W     = 7;
   localparam int unsigned Y_W     = 5;
   localparam int unsigned RATE_W  = 10;
   localparam int unsigned CSR_IDX_W = 2;

   typedef logic [CSR_IDX_W-1:0] csr_idx_type;
   localparam csr_idx_type CSR_TEXT_COLOR   = 2'd0;
   localparam csr_idx_type CSR_SHADOW_COLOR = 2'd1;
   localparam csr_idx_type CSR_FRAME_COLOR  = 2'd2;
   localparam csr_idx_type CSR_FILL_COLOR   = 2'd3;

   localparam logic [COLOR_W-1:0] TEXT_COLOR_RST   = 32'hff00ff40;
   localparam logic [COLOR_W-1:0] SHADOW_COLOR_RST = 32'hff000000;
   localparam logic [COLOR_W-1:0] FRAME_COLOR_RST  = 32'hd0202020;
   localparam logic [COLOR_W-1:0] FILL_COLOR_RST   = 32'hb0101010;

   localparam logic [RATE_W-1:0] MAX_RATE = 10'd999;
   localparam logic [X_W-1:0]    TEXT_X0  = 7'd8;
   localparam logic [Y_W-1:0]    TEXT_Y0  = 5'd5;
   localparam logic [6:0]        CHAR_PITCH = 7'd13;
   // Rows 5..18 hold the seven doubled glyph rows.
   localparam logic [Y_W-1:0]    TEXT_ROWS2 = 5'd14;
   localparam logic [3:0]        CELL_COLS2 = 4'd10;

   typedef logic [3:0] sym_type;
   localparam sym_type SYM_SPACE = 4'd10;
   localparam sym_type SYM_F     = 4'd11;
   localparam sym_type SYM_P     = 4'd12;
   localparam sym_type SYM_S     = 4'd13;
   localparam sym_type SYM_BLANK = 4'd14;

   typedef logic [4:0][6:0] glyph_type;

   // Column c of a glyph is element [c]; bit r of a column is row r.
   function automatic glyph_type glyph_bits(sym_type sym);
      glyph_type g;
      case (sym)
         4'd0:    g = {7'h3e, 7'h45, 7'h49, 7'h51, 7'h3e};
         4'd1:    g = {7'h00, 7'h40, 7'h7f, 7'h42, 7'h00};
         4'd2:    g = {7'h46, 7'h49, 7'h51, 7'h61, 7'h42};
         4'd3:    g = {7'h31, 7'h4b, 7'h45, 7'h41, 7'h21};
         4'd4:    g = {7'h10, 7'h7f, 7'h12, 7'h14, 7'h18};
         4'd5:    g = {7'h39, 7'h45, 7'h45, 7'h45, 7'h27};
         4'd6:    g = {7'h30, 7'h49, 7'h49, 7'h4a, 7'h3c};
         4'd7:    g = {7'h03, 7'h05, 7'h09, 7'h71, 7'h01};
         4'd8:    g = {7'h36, 7'h49, 7'h49, 7'h49, 7'h36};
         4'd9:    g = {7'h1e, 7'h29, 7'h49, 7'h49, 7'h06};
         SYM_F:   g = {7'h01, 7'h01, 7'h09, 7'h09, 7'h7f};
         SYM_P:   g = {7'h06, 7'h09, 7'h09, 7'h09, 7'h7f};
         SYM_S:   g = {7'h32, 7'h49, 7'h49, 7'h49, 7'h26};
         default: g = '0;
      endcase
      return g;
   endfunction

endpackage

// ===== src/frtov_if.sv =====
// Valid/ready channel interfaces for pixel requests and pixel responses.
interface frtov_req_if;
   logic                           valid;
   logic                           ready;
   logic [frtov_pkg::X_W-1:0]      pixel_x;
   logic [frtov_pkg::Y_W-1:0]      pixel_y;
   logic [frtov_pkg::RATE_W-1:0]   frame_rate;

   modport source (output valid, output pixel_x, output pixel_y, output frame_rate,
                   input ready);
   modport sink   (input valid, input pixel_x, input pixel_y, input frame_rate,
                   output ready);
endinterface

interface frtov_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [frtov_pkg::COLOR_W-1:0]  pixel_word;

   modport source (output valid, output pixel_word, input ready);
   modport sink   (input valid, input pixel_word, output ready);
endinterface

// ===== src/frame_rate_text_overlay_unit.sv =====
// Frame-rate badge overlay: five-stage pixel pipeline with color registers.
//
// Usage: each beat on req_bus carries one tile coordinate (pixel_x, pixel_y)
// and the frame rate to show. Each accepted beat yields exactly one beat on
// rsp_bus with the RGBA word of that pixel, in request order. Rates above 999
// are shown as 999; coordinates outside the tile return zero.
// Pipeline: five register stages (A..E); a beat passes A, B, C, D and E in
// order, presented on rsp_bus from E. Throughput: one beat per cycle while
// rsp_bus is ready, set by the per-stage valid/enable chain; no stage iterates.
// Stalls: each stage advances when it is empty or the stage after it moves,
// so bubbles collapse and req_bus.ready stays high while any stage is free.
// A stalled response holds in the output register with nothing lost.
// Colors: csr_we writes register csr_index (text, shadow, frame, fill) with
// csr_wdata; write only while the pipeline is empty.
// Reset (synchronous, active high): empties the pipeline and restores the
// default colors.
`include "frame_rate_text_overlay_unit_defines.svh"

module frame_rate_text_overlay_unit #(
   parameter int unsigned TILE_WIDTH  = 104,
   parameter int unsigned TILE_HEIGHT = 26
) (
   input  logic                                clock,
   input  logic                                reset,
   frtov_req_if.sink                           req_bus,
   frtov_rsp_if.source                         rsp_bus,
   input  logic                                csr_we,
   input  frtov_pkg::csr_idx_type              csr_index,
   input  logic [frtov_pkg::COLOR_W-1:0]       csr_wdata
);

   localparam logic [8:0] TILE_W9 = 9'(TILE_WIDTH);
   localparam logic [8:0] X_LAST  = 9'(TILE_WIDTH - 1);
   localparam logic [6:0] TILE_H7 = 7'(TILE_HEIGHT);
   localparam logic [6:0] Y_LAST  = 7'(TILE_HEIGHT - 1);

   // Position of one pixel against the text grid, before and after the
   // character offset is resolved.
   typedef struct packed {
      logic       ok;
      logic [6:0] rel;
      logic [3:0] chr;
      logic [2:0] row;
   } pre_type;

   typedef struct packed {
      logic       hit;
      logic [3:0] chr;
      logic [2:0] col;
      logic [2:0] row;
   } pos_type;

   typedef struct packed {
      logic outside;
      logic xe;
      logic ye;
   } bg_type;

   typedef struct packed {
      logic [3:0] hund;
      logic [3:0] tens;
      logic [3:0] ones;
      logic [1:0] nd;
   } digits_type;

   // Locate a pixel on the text grid; divide by the pitch with a reciprocal.
   function automatic pre_type text_pre(logic [6:0] px, logic [4:0] py, logic en);
      pre_type    p;
      logic [4:0] dy;
      logic [13:0] prod;
      dy       = py - frtov_pkg::TEXT_Y0;
      p.rel    = px - frtov_pkg::TEXT_X0;
      prod     = 14'(p.rel) * 14'd79;
      p.chr    = prod[13:10];
      p.row    = dy[3:1];
      p.ok     = en && (px >= frtov_pkg::TEXT_X0) && (py >= frtov_pkg::TEXT_Y0)
                 && ({2'b00, px} < TILE_W9) && ({2'b00, py} < TILE_H7)
                 && (dy < frtov_pkg::TEXT_ROWS2);
      return p;
   endfunction

   function automatic pos_type text_pos(pre_type p);
      pos_type    q;
      logic [6:0] off;
      off   = p.rel - (7'(p.chr) * frtov_pkg::CHAR_PITCH);
      q.hit = p.ok && (off[3:0] < frtov_pkg::CELL_COLS2);
      q.chr = p.chr;
      q.col = off[3:1];
      q.row = p.row;
      return q;
   endfunction

   // Symbol shown at character slot k: digits without leading zeros, then " FPS".
   function automatic frtov_pkg::sym_type char_sym(logic [3:0] k, digits_type d);
      frtov_pkg::sym_type s;
      logic [3:0]         j;
      logic [3:0]         sel;
      j   = k - 4'(d.nd);
      sel = k + 4'(2'd3 - d.nd);
      if (k < 4'(d.nd)) begin
         case (sel)
            4'd0:    s = d.hund;
            4'd1:    s = d.tens;
            default: s = d.ones;
         endcase
      end else if (j < 4'd4) begin
         s = frtov_pkg::SYM_SPACE + j;
      end else begin
         s = frtov_pkg::SYM_BLANK;
      end
      return s;
   endfunction

   function automatic logic pos_lit(pos_type p, digits_type d);
      frtov_pkg::glyph_type g;
      g = frtov_pkg::glyph_bits(char_sym(p.chr, d));
      return p.hit && g[p.col][p.row];
   endfunction

   // ---------------------------------------------------------------- colors
   logic [frtov_pkg::COLOR_W-1:0] text_color_ff,   text_color_in;
   logic [frtov_pkg::COLOR_W-1:0] shadow_color_ff, shadow_color_in;
   logic [frtov_pkg::COLOR_W-1:0] frame_color_ff,  frame_color_in;
   logic [frtov_pkg::COLOR_W-1:0] fill_color_ff,   fill_color_in;

   always_comb begin
      text_color_in   = text_color_ff;
      shadow_color_in = shadow_color_ff;
      frame_color_in  = frame_color_ff;
      fill_color_in   = fill_color_ff;
      if (csr_we) begin
         unique case (csr_index)
            frtov_pkg::CSR_TEXT_COLOR:   text_color_in   = csr_wdata;
            frtov_pkg::CSR_SHADOW_COLOR: shadow_color_in = csr_wdata;
            frtov_pkg::CSR_FRAME_COLOR:  frame_color_in  = csr_wdata;
            frtov_pkg::CSR_FILL_COLOR:   fill_color_in   = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         text_color_ff   <= frtov_pkg::TEXT_COLOR_RST;
         shadow_color_ff <= frtov_pkg::SHADOW_COLOR_RST;
         frame_color_ff  <= frtov_pkg::FRAME_COLOR_RST;
         fill_color_ff   <= frtov_pkg::FILL_COLOR_RST;
      end else begin
         text_color_ff   <= text_color_in;
         shadow_color_ff <= shadow_color_in;
         frame_color_ff  <= frame_color_in;
         fill_color_ff   <= fill_color_in;
      end
   end

   // ------------------------------------------------------- stage enables
   logic a_valid_ff, b_valid_ff, c_valid_ff, d_valid_ff, e_valid_ff;
   logic a_valid_in, b_valid_in, c_valid_in, d_valid_in, e_valid_in;
   logic adv_a, adv_b, adv_c, adv_d, adv_e;

   // A stage moves when it is empty or its successor moves.
   assign adv_e = !e_valid_ff || rsp_bus.ready;
   assign adv_d = !d_valid_ff || adv_e;
   assign adv_c = !c_valid_ff || adv_d;
   assign adv_b = !b_valid_ff || adv_c;
   assign adv_a = !a_valid_ff || adv_b;

   assign req_bus.ready = adv_a;

   assign a_valid_in = adv_a ? req_bus.valid : a_valid_ff;
   assign b_valid_in = adv_b ? a_valid_ff    : b_valid_ff;
   assign c_valid_in = adv_c ? b_valid_ff    : c_valid_ff;
   assign d_valid_in = adv_d ? c_valid_ff    : d_valid_ff;
   assign e_valid_in = adv_e ? d_valid_ff    : e_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
         e_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
         c_valid_ff <= c_valid_in;
         d_valid_ff <= d_valid_in;
         e_valid_ff <= e_valid_in;
      end
   end

   // ----------------------------------------------------------- stage A
   // Saturate the rate, take the hundreds digit, locate both the pixel and
   // its up-left neighbor on the text grid, flag edges.
   logic [9:0]  a_rate_ff,  a_rate_in;
   logic [3:0]  a_hund_ff,  a_hund_in;
   pre_type     a_self_ff,  a_self_in;
   pre_type     a_diag_ff,  a_diag_in;
   bg_type      a_bg_ff,    a_bg_in;
   logic [9:0]  sat_rate;
   logic [15:0] hund_prod;

   always_comb begin
      sat_rate  = (req_bus.frame_rate > frtov_pkg::MAX_RATE) ? frtov_pkg::MAX_RATE
                                                             : req_bus.frame_rate;
      hund_prod = 16'(sat_rate) * 16'd41;
      a_rate_in = sat_rate;
      a_hund_in = hund_prod[15:12];
      a_self_in = text_pre(req_bus.pixel_x, req_bus.pixel_y, 1'b1);
      a_diag_in = text_pre(req_bus.pixel_x - 7'd1, req_bus.pixel_y - 5'd1,
                           (req_bus.pixel_x != '0) && (req_bus.pixel_y != '0));
      a_bg_in.outside = ({2'b00, req_bus.pixel_x} >= TILE_W9)
                        || ({2'b00, req_bus.pixel_y} >= TILE_H7);
      a_bg_in.xe = (req_bus.pixel_x == '0) || ({2'b00, req_bus.pixel_x} == X_LAST);
      a_bg_in.ye = (req_bus.pixel_y == '0) || ({2'b00, req_bus.pixel_y} == Y_LAST);
   end

   always_ff @(posedge clock) begin
      if (adv_a) begin
         a_rate_ff <= a_rate_in;
         a_hund_ff <= a_hund_in;
         a_self_ff <= a_self_in;
         a_diag_ff <= a_diag_in;
         a_bg_ff   <= a_bg_in;
      end
   end

   // ----------------------------------------------------------- stage B
   // Remainder below one hundred; character column offsets.
   logic [6:0]  b_rem_ff,  b_rem_in;
   logic [3:0]  b_hund_ff;
   pos_type     b_self_ff, b_self_in;
   pos_type     b_diag_ff, b_diag_in;
   bg_type      b_bg_ff;
   logic [9:0]  rem_full;

   always_comb begin
      rem_full  = a_rate_ff - (10'(a_hund_ff) * 10'd100);
      b_rem_in  = rem_full[6:0];
      b_self_in = text_pos(a_self_ff);
      b_diag_in = text_pos(a_diag_ff);
   end

   always_ff @(posedge clock) begin
      if (adv_b) begin
         b_rem_ff  <= b_rem_in;
         b_hund_ff <= a_hund_ff;
         b_self_ff <= b_self_in;
         b_diag_ff <= b_diag_in;
         b_bg_ff   <= a_bg_ff;
      end
   end

   // ----------------------------------------------------------- stage C
   // Tens and ones digits and the digit count.
   digits_type  c_dig_ff, c_dig_in;
   pos_type     c_self_ff;
   pos_type     c_diag_ff;
   bg_type      c_bg_ff;
   logic [13:0] tens_prod;
   logic [6:0]  ones_full;

   always_comb begin
      tens_prod     = 14'(b_rem_ff) * 14'd103;
      ones_full     = b_rem_ff - (7'(tens_prod[13:10]) * 7'd10);
      c_dig_in.hund = b_hund_ff;
      c_dig_in.tens = tens_prod[13:10];
      c_dig_in.ones = ones_full[3:0];
      if (b_hund_ff != '0) begin
         c_dig_in.nd = 2'd3;
      end else if (tens_prod[13:10] != '0) begin
         c_dig_in.nd = 2'd2;
      end else begin
         c_dig_in.nd = 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (adv_c) begin
         c_dig_ff  <= c_dig_in;
         c_self_ff <= b_self_ff;
         c_diag_ff <= b_diag_ff;
         c_bg_ff   <= b_bg_ff;
      end
   end

   // ----------------------------------------------------------- stage D
   // Font lookup for the pixel and its up-left neighbor.
   logic   d_lit_ff,  d_lit_in;
   logic   d_shad_ff, d_shad_in;
   bg_type d_bg_ff;

   assign d_lit_in  = pos_lit(c_self_ff, c_dig_ff);
   assign d_shad_in = pos_lit(c_diag_ff, c_dig_ff);

   always_ff @(posedge clock) begin
      if (adv_d) begin
         d_lit_ff  <= d_lit_in;
         d_shad_ff <= d_shad_in;
         d_bg_ff   <= c_bg_ff;
      end
   end

   // ----------------------------------------------------------- stage E
   // Pick the color word; this is the output register.
   logic [frtov_pkg::COLOR_W-1:0] e_word_ff, e_word_in;

   always_comb begin
      if (d_bg_ff.outside) begin
         e_word_in = '0;
      end else if (d_lit_ff) begin
         e_word_in = text_color_ff;
      end else if (d_shad_ff) begin
         e_word_in = shadow_color_ff;
      end else if (d_bg_ff.xe && d_bg_ff.ye) begin
         e_word_in = '0;
      end else if (d_bg_ff.xe || d_bg_ff.ye) begin
         e_word_in = frame_color_ff;
      end else begin
         e_word_in = fill_color_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv_e) begin
         e_word_ff <= e_word_in;
      end
   end

   assign rsp_bus.valid      = e_valid_ff;
   assign rsp_bus.pixel_word = e_word_ff;

   // ------------------------------------------------------------ checks
   // Back-pressure reaches the input only when the output register is full.
   `FRTOV_ASSERT_NOW(a_stall_needs_full_out, clock, reset, !req_bus.ready, e_valid_ff && !rsp_bus.ready)
   // The saturated rate never exceeds the displayable maximum.
   `FRTOV_ASSERT_NOW(a_rate_saturated, clock, reset, a_valid_ff, a_rate_ff <= frtov_pkg::MAX_RATE)
   // Every decimal digit stays a digit.
   `FRTOV_ASSERT_NOW(a_digits_decimal, clock, reset, c_valid_ff, (c_dig_ff.hund < 4'd10) && (c_dig_ff.tens < 4'd10) && (c_dig_ff.ones < 4'd10))
   // A pixel outside the tile leaves the pipe as a zero word.
   `FRTOV_ASSERT_NEXT(a_outside_zero, clock, reset, d_valid_ff && adv_e && d_bg_ff.outside, rsp_bus.pixel_word == '0)

endmodule
